// ===== rtl/pidaw_pkg.sv =====
// Shared widths, register indexes and reset values for the PID controller.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package pidaw_pkg;

  // Field and state widths
  localparam int DataW  = 16;
  localparam int FracW  = 8;
  localparam int AccW   = 32;
  localparam int ErrW   = DataW + 1;
  localparam int DerrW  = DataW + 2;
  // Weighted sum: gain * integral plus two narrower terms
  localparam int ProdW  = AccW + DataW + 2;
  localparam int ShW    = ProdW - FracW;
  // Bound dividend: limit span shifted up by the fraction bits
  localparam int DivW   = DataW + FracW;
  localparam int BndW   = DivW + 2;
  localparam int CmpW   = AccW + 2;

  // Register map
  localparam int NumRegs = 7;
  localparam int AddrW   = $clog2(NumRegs) + 2;
  localparam int IdxW    = $clog2(NumRegs);

  localparam logic [IdxW-1:0] RegSetpoint  = IdxW'(0);
  localparam logic [IdxW-1:0] RegPropGain  = IdxW'(1);
  localparam logic [IdxW-1:0] RegIntGain   = IdxW'(2);
  localparam logic [IdxW-1:0] RegDerivGain = IdxW'(3);
  localparam logic [IdxW-1:0] RegLowerLim  = IdxW'(4);
  localparam logic [IdxW-1:0] RegUpperLim  = IdxW'(5);
  localparam logic [IdxW-1:0] RegOffset    = IdxW'(6);

  localparam logic signed [DataW-1:0] LowerLimRst = -DataW'(100);
  localparam logic signed [DataW-1:0] UpperLimRst = DataW'(100);

endpackage

// ===== rtl/pidaw_sermul.sv =====
// Bit-serial signed multiplier: one gain bit per cycle, shift and add.
// Depends on pidaw_pkg for the operand and product widths.
`timescale 1ns / 1ps
module pidaw_sermul (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [pidaw_pkg::ProdW-1:0] mcand_i,
  input  logic signed [pidaw_pkg::DataW-1:0] mplier_i,
  output logic                              busy_o,
  output logic signed [pidaw_pkg::ProdW-1:0] prod_o
);
  import pidaw_pkg::*;

  localparam int CntW = $clog2(DataW);

  logic                    busy_q;
  logic [CntW-1:0]         cnt_q;
  logic signed [ProdW-1:0] acc_q;
  logic signed [ProdW-1:0] mc_q;
  logic [DataW-1:0]        mp_q;

  // Control: run one step per gain bit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DataW - 1)) busy_q <= 1'b0;
    end
  end

  // Datapath: the sign bit of the gain weighs negatively
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      mc_q  <= mcand_i;
      mp_q  <= mplier_i;
    end else if (busy_q) begin
      if (mp_q[0]) begin
        if (cnt_q == CntW'(DataW - 1)) acc_q <= acc_q - mc_q;
        else acc_q <= acc_q + mc_q;
      end
      mc_q <= mc_q <<< 1;
      mp_q <= mp_q >> 1;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

// ===== rtl/pidaw_serdiv.sv =====
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pidaw_pkg for the dividend and divisor widths.
`timescale 1ns / 1ps
module pidaw_serdiv (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pidaw_pkg::DivW-1:0]  dividend_i,
  input  logic [pidaw_pkg::DataW-1:0] divisor_i,
  output logic                        busy_o,
  output logic [pidaw_pkg::DivW-1:0]  quot_o
);
  import pidaw_pkg::*;

  localparam int CntW = $clog2(DivW);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [DataW-1:0]  rem_q;
  logic [DataW-1:0]  dvs_q;
  logic [DivW-1:0]   quot_q;
  logic [DataW:0]    trial;
  logic              fits;

  // Shift in the next dividend bit and try the subtraction
  assign trial = {rem_q, quot_q[DivW-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CntW'(1);
      if (cnt_q == CntW'(DivW - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      dvs_q  <= divisor_i;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      if (fits) rem_q <= DataW'(trial - {1'b0, dvs_q});
      else rem_q <= trial[DataW-1:0];
      quot_q <= {quot_q[DivW-2:0], fits};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/pid_controller_antiwindup.sv =====
// PID controller with conditional-integration anti-windup. One measured sample
// in, one clamped drive value out. Each request passes from acceptance to the
// edge that raises the result through a load state, three bit-serial
// multipliers (proportional, derivative, trial integral) running alongside the
// bound divider, the trial sum, the integral update together with the start of
// the second integral multiply, that multiply, the final sum and the output
// register. The next request is accepted in the cycle after the result is
// registered; a result held at the output stalls the sequencer only when the
// next result is ready to take its place. One request is in flight at a time.
// Registers sit on an APB-style port at byte addresses 4*i; write them only
// while the block is idle.
// Depends on pidaw_pkg, pidaw_sermul and pidaw_serdiv.
`timescale 1ns / 1ps
module pid_controller_antiwindup (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pidaw_pkg::AddrW-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  // Sample channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pidaw_pkg::DataW-1:0]  measured_i,
  // Drive channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pidaw_pkg::DataW-1:0]  drive_o
);
  import pidaw_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_LOAD = 7'b0000010,
    S_MUL1 = 7'b0000100,
    S_TRY  = 7'b0001000,
    S_DEC  = 7'b0010000,
    S_MUL2 = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic signed [DataW-1:0] sp_q, kp_q, ki_q, kd_q, lo_lim_q, hi_lim_q, off_q;
  logic                    cfg_wr;
  logic [IdxW-1:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[AddrW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q     <= '0;
      kp_q     <= '0;
      ki_q     <= '0;
      kd_q     <= '0;
      lo_lim_q <= LowerLimRst;
      hi_lim_q <= UpperLimRst;
      off_q    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        RegSetpoint:  sp_q     <= pwdata[DataW-1:0];
        RegPropGain:  kp_q     <= pwdata[DataW-1:0];
        RegIntGain:   ki_q     <= pwdata[DataW-1:0];
        RegDerivGain: kd_q     <= pwdata[DataW-1:0];
        RegLowerLim:  lo_lim_q <= pwdata[DataW-1:0];
        RegUpperLim:  hi_lim_q <= pwdata[DataW-1:0];
        RegOffset:    off_q    <= pwdata[DataW-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (cfg_idx)
      RegSetpoint:  prdata = {{(32-DataW){1'b0}}, sp_q};
      RegPropGain:  prdata = {{(32-DataW){1'b0}}, kp_q};
      RegIntGain:   prdata = {{(32-DataW){1'b0}}, ki_q};
      RegDerivGain: prdata = {{(32-DataW){1'b0}}, kd_q};
      RegLowerLim:  prdata = {{(32-DataW){1'b0}}, lo_lim_q};
      RegUpperLim:  prdata = {{(32-DataW){1'b0}}, hi_lim_q};
      RegOffset:    prdata = {{(32-DataW){1'b0}}, off_q};
      default:      prdata = '0;
    endcase
  end

  // Controller state and per-request operands
  logic signed [ErrW-1:0]  prev_q, err_q, err_d;
  logic signed [DerrW-1:0] derr_q, derr_d;
  logic signed [AccW-1:0]  isum_q, isum_d, trial_q, trial_d;
  logic signed [DataW-1:0] lo_q, hi_q;
  logic signed [AccW:0]    trial_wide;
  logic                    in_acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;

  assign err_d      = ErrW'(sp_q) - ErrW'(measured_i);
  assign derr_d     = DerrW'(err_d) - DerrW'(prev_q);
  assign trial_wide = (AccW+1)'(isum_q) + (AccW+1)'(err_d);

  // Saturate the trial integral to the accumulator width
  always_comb begin
    if (trial_wide[AccW] != trial_wide[AccW-1]) begin
      trial_d = trial_wide[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      trial_d = trial_wide[AccW-1:0];
    end
  end

  // Capture operands on acceptance
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      err_q   <= err_d;
      derr_q  <= derr_d;
      trial_q <= trial_d;
      if (lo_lim_q > hi_lim_q) begin
        lo_q <= hi_lim_q;
        hi_q <= lo_lim_q;
      end else begin
        lo_q <= lo_lim_q;
        hi_q <= hi_lim_q;
      end
    end
  end

  // Serial units
  logic                    mul_start, int_start, div_start;
  logic                    p_busy, d_busy, i_busy, div_busy;
  logic signed [ProdW-1:0] p_prod, d_prod, i_prod, i_mcand;
  logic [DataW-1:0]        ki_mag;
  logic [DataW:0]          span;
  logic [DivW-1:0]         quot;

  assign mul_start = (state_q == S_LOAD);
  assign int_start = (state_q == S_LOAD) || (state_q == S_DEC);
  assign div_start = (state_q == S_LOAD);
  assign i_mcand   = (state_q == S_DEC) ? ProdW'(isum_d) : ProdW'(trial_q);
  assign ki_mag    = ki_q[DataW-1] ? DataW'(-ki_q) : DataW'(ki_q);
  assign span      = (DataW+1)'(hi_q) - (DataW+1)'(lo_q);

  pidaw_sermul u_mul_p (
    .clk_i, .rst_ni, .start_i(mul_start), .mcand_i(ProdW'(err_q)),
    .mplier_i(kp_q), .busy_o(p_busy), .prod_o(p_prod)
  );

  pidaw_sermul u_mul_d (
    .clk_i, .rst_ni, .start_i(mul_start), .mcand_i(ProdW'(derr_q)),
    .mplier_i(kd_q), .busy_o(d_busy), .prod_o(d_prod)
  );

  pidaw_sermul u_mul_i (
    .clk_i, .rst_ni, .start_i(int_start), .mcand_i(i_mcand),
    .mplier_i(ki_q), .busy_o(i_busy), .prod_o(i_prod)
  );

  pidaw_serdiv u_div (
    .clk_i, .rst_ni, .start_i(div_start),
    .dividend_i({span[DataW-1:0], {FracW{1'b0}}}), .divisor_i(ki_mag),
    .busy_o(div_busy), .quot_o(quot)
  );

  // Trial output and partial sum
  logic signed [ProdW-1:0] pd_q;
  logic signed [ShW-1:0]   tout_q, drv_q;
  logic signed [ProdW-1:0] tsum, fsum;

  assign tsum = p_prod + d_prod + i_prod;
  assign fsum = pd_q + i_prod;

  always_ff @(posedge clk_i) begin
    if (state_q == S_TRY) begin
      pd_q   <= p_prod + d_prod;
      tout_q <= ShW'(tsum >>> FracW);
    end
    if (state_q == S_MUL2 && !i_busy) drv_q <= ShW'(fsum >>> FracW);
  end

  // Conditional integration and bound
  logic                   in_band, opposes;
  logic signed [AccW-1:0] isum_sel;
  logic signed [BndW-1:0] bnd;
  logic signed [CmpW-1:0] c1, c2;

  assign in_band = (tout_q > ShW'(lo_q)) && (tout_q < ShW'(hi_q));
  assign opposes = (err_q < 0 && isum_q > 0) || (err_q > 0 && isum_q < 0);

  always_comb begin
    isum_sel = (in_band || opposes) ? trial_q : isum_q;
    bnd      = ki_q[DataW-1] ? -BndW'({1'b0, quot}) : BndW'({1'b0, quot});
    c1       = (CmpW'(isum_sel) > CmpW'(bnd)) ? CmpW'(bnd) : CmpW'(isum_sel);
    c2       = (c1 < -CmpW'(bnd)) ? -CmpW'(bnd) : c1;
    isum_d   = (ki_q == '0) ? '0 : c2[AccW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      isum_q <= '0;
    end else begin
      if (in_acc) prev_q <= err_d;
      if (state_q == S_DEC) isum_q <= isum_d;
    end
  end

  // Offset away from zero, then clamp
  logic signed [ShW-1:0]   d1, d2;
  logic signed [DataW-1:0] drive_d;

  always_comb begin
    d1 = (drv_q > 0) ? drv_q + ShW'(off_q) : drv_q;
    d2 = (d1 < 0) ? d1 - ShW'(off_q) : d1;
    if (d2 > ShW'(hi_q)) drive_d = hi_q;
    else if (d2 < ShW'(lo_q)) drive_d = lo_q;
    else drive_d = d2[DataW-1:0];
  end

  // Sequencer
  logic out_free;
  assign out_free = !out_valid_o || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_LOAD;
      S_LOAD: state_d = S_MUL1;
      S_MUL1: if (!p_busy && !d_busy && !i_busy && !div_busy) state_d = S_TRY;
      S_TRY:  state_d = S_DEC;
      S_DEC:  state_d = S_MUL2;
      S_MUL2: if (!i_busy) state_d = S_OUT;
      S_OUT:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  // Output register
  logic out_valid_q;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == S_OUT && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_free) drive_o <= drive_d;
  end

endmodule

// ===== rtl/pidaw_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
// Depends on pidaw_pkg and pid_controller_antiwindup.
`timescale 1ns / 1ps
module pidaw_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                pready,
  input logic                                in_valid_i,
  input logic                                in_ready_o,
  input logic                                out_valid_o,
  input logic                                out_ready_i,
  input logic signed [pidaw_pkg::DataW-1:0]  drive_o
);
  import pidaw_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(drive_o))
    else $error("stalled drive changed or dropped");

  // Take one request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second request accepted while busy");

  // Raise no new result too soon after an accepted request
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> ##1 !$rose(out_valid_o))
    else $error("result appeared too early");

  // Keep the configuration port always ready
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind pid_controller_antiwindup pidaw_checker u_pidaw_checker (
  .clk_i, .rst_ni, .pready, .in_valid_i, .in_ready_o,
  .out_valid_o, .out_ready_i, .drive_o
);
